// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ABRS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define ABRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/abrs_pkg.sv =====
// types and constants of the angle bucket range smoother
package abrs_pkg;

    localparam int NUM_BUCKETS = 360;
    localparam int BKT_W       = 9;
    localparam int DIST_W      = 20;
    localparam int MUL_A_W     = 18;
    localparam int MUL_B_W     = 20;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // ceil(2^24 / 100), exact floor division for dividends below 2^17
    localparam logic [MUL_A_W-1:0] RECIP_100   = 18'd167773;
    localparam int                 RECIP_SHIFT = 24;

    localparam logic [8:0] ONE_Q8 = 9'd256;

    localparam logic [8:0]  ALPHA_RESET     = 9'd77;
    localparam logic [15:0] THRESHOLD_RESET = 16'd500;
    localparam logic [8:0]  DECAY_RESET     = 9'd230;
    localparam logic [8:0]  MIN_CONF_RESET  = 9'd26;
    localparam logic [8:0]  BOOST_RESET     = 9'd77;

    localparam logic [2:0] CFG_ALPHA     = 3'd0;
    localparam logic [2:0] CFG_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_DECAY     = 3'd2;
    localparam logic [2:0] CFG_MIN_CONF  = 3'd3;
    localparam logic [2:0] CFG_BOOST     = 3'd4;

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_DECAY = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] range_q4;
        logic [15:0]       angle;
        logic [7:0]        qual;
        logic [8:0]        conf;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [BKT_W-1:0] wr_addr;
        logic             rd_en;
        logic [BKT_W-1:0] rd_addr;
    } tbl_req_t;

endpackage

// ===== sv/abrs_table.sv =====
// bucket table memory, one write and one registered read per cycle
module abrs_table (
    input  logic              clk,
    input  abrs_pkg::tbl_req_t req,
    input  abrs_pkg::entry_t   wr_data,
    output abrs_pkg::entry_t   rd_data
);

    abrs_pkg::entry_t mem [abrs_pkg::NUM_BUCKETS];
    abrs_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/abrs_mul.sv =====
// shared unsigned multiplier with registered product
module abrs_mul (
    input  logic                           clk,
    input  logic [abrs_pkg::MUL_A_W-1:0]   a,
    input  logic [abrs_pkg::MUL_B_W-1:0]   b,
    output logic [abrs_pkg::MUL_P_W-1:0]   prod
);

    logic [abrs_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= abrs_pkg::MUL_P_W'(a) * abrs_pkg::MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== sv/angle_bucket_range_smoother.sv =====
// top level: sequencer, configuration registers and result registers
//
// channel   | handshake             | words
// ----------+-----------------------+-------------------------------------------
// command   | start / busy          | opcode, angle, distance, quality, bucket
// result    | done strobe           | entry, index, distance, angle, quality ...
// config    | cfg_write             | cfg_index, cfg_data
//
// a decay sweep steps through all 360 buckets; points and decay steps share the
// one multiplier, and points, reads and decay steps the single table read port,
// one step per cycle
// after reset a clearing pass over all 360 buckets runs with busy high
// a result shows for one cycle with done; busy drops in that same cycle
`include "assert_macros.svh"

module angle_bucket_range_smoother (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] angle_centideg,
    input  logic [15:0] distance_mm,
    input  logic [7:0]  quality,
    input  logic [8:0]  read_bucket,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic        entry_present,
    output logic [8:0]  bucket_index,
    output logic [19:0] smoothed_distance,
    output logic [15:0] last_angle,
    output logic [7:0]  last_quality,
    output logic [8:0]  confidence,
    output logic [8:0]  live_entries
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_DIFF,
        S_WRITE,
        S_READ,
        S_RDOUT,
        S_DRD,
        S_DMUL,
        S_DWR,
        S_NOP
    } state_t;

    localparam logic [8:0] LAST_BKT = 9'(abrs_pkg::NUM_BUCKETS - 1);
    localparam logic [8:0] N_BKT    = 9'(abrs_pkg::NUM_BUCKETS);

    state_t state_reg;

    logic [8:0]  alpha_reg;
    logic [15:0] thr_reg;
    logic [8:0]  decay_reg;
    logic [8:0]  min_conf_reg;
    logic [8:0]  boost_reg;

    logic [15:0] ang_reg;
    logic [15:0] dist_reg;
    logic [7:0]  qual_reg;
    logic [8:0]  rb_reg;
    logic [8:0]  bkt_reg;
    logic [8:0]  idx_reg;
    logic [8:0]  live_reg;
    logic [8:0]  live_next;

    logic        done_reg;
    logic        present_reg;
    logic [8:0]  index_reg;
    logic [19:0] dist_out_reg;
    logic [15:0] angle_out_reg;
    logic [7:0]  qual_out_reg;
    logic [8:0]  conf_out_reg;
    logic [8:0]  live_out_reg;

    abrs_pkg::tbl_req_t tbl_req;
    abrs_pkg::entry_t   tbl_wr_data;
    abrs_pkg::entry_t   rd;

    logic [abrs_pkg::MUL_A_W-1:0] mul_a;
    logic [abrs_pkg::MUL_B_W-1:0] mul_b;
    logic [abrs_pkg::MUL_P_W-1:0] prod;

    logic [16:0] ang_sum;
    logic [9:0]  quot;
    logic [8:0]  bkt_calc;
    logic [19:0] nd;
    logic        nd_ge;
    logic [19:0] diff;
    logic        jump;
    logic [8:0]  alpha_sat;
    logic [8:0]  alpha_eff;
    logic [8:0]  decay_sat;
    logic [29:0] base30;
    logic [29:0] term30;
    logic [29:0] blend30;
    logic [19:0] new_dist;
    logic [9:0]  conf_sum;
    logic [8:0]  conf_upd;
    logic [8:0]  dec_conf;
    logic        drop;
    logic        rb_in_range;
    logic        last_idx;
    abrs_pkg::entry_t point_entry;
    abrs_pkg::entry_t decay_entry;

    abrs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    abrs_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .wr_data (tbl_wr_data),
        .rd_data (rd)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= abrs_pkg::ALPHA_RESET;
            thr_reg      <= abrs_pkg::THRESHOLD_RESET;
            decay_reg    <= abrs_pkg::DECAY_RESET;
            min_conf_reg <= abrs_pkg::MIN_CONF_RESET;
            boost_reg    <= abrs_pkg::BOOST_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                abrs_pkg::CFG_ALPHA:     alpha_reg    <= cfg_data[8:0];
                abrs_pkg::CFG_THRESHOLD: thr_reg      <= cfg_data;
                abrs_pkg::CFG_DECAY:     decay_reg    <= cfg_data[8:0];
                abrs_pkg::CFG_MIN_CONF:  min_conf_reg <= cfg_data[8:0];
                abrs_pkg::CFG_BOOST:     boost_reg    <= cfg_data[8:0];
                default:                 ;
            endcase
        end
    end

    // bucket from angle: floor((angle + 50) / 100) mod 360
    assign ang_sum  = {1'b0, ang_reg} + 17'd50;
    assign quot     = prod[abrs_pkg::RECIP_SHIFT+9:abrs_pkg::RECIP_SHIFT];
    assign bkt_calc = (quot >= {1'b0, N_BKT}) ? 9'(quot - {1'b0, N_BKT}) : quot[8:0];

    // smoothing path
    assign nd        = {dist_reg, 4'b0000};
    assign nd_ge     = nd >= rd.range_q4;
    assign diff      = nd_ge ? (nd - rd.range_q4) : (rd.range_q4 - nd);
    assign jump      = diff > {thr_reg, 4'b0000};
    assign alpha_sat = (alpha_reg > abrs_pkg::ONE_Q8) ? abrs_pkg::ONE_Q8 : alpha_reg;
    assign alpha_eff = jump ? (alpha_sat >> 1) : alpha_sat;
    assign decay_sat = (decay_reg > abrs_pkg::ONE_Q8) ? abrs_pkg::ONE_Q8 : decay_reg;

    // od * 256 +/- a * |nd - od|, rounded half up
    assign base30   = {2'b00, rd.range_q4, 8'b0000_0000};
    assign term30   = prod[29:0];
    assign blend30  = nd_ge ? (base30 + term30 + 30'd128) : (base30 - term30 + 30'd128);
    assign new_dist = blend30[27:8];

    assign conf_sum = {1'b0, rd.conf} + {1'b0, boost_reg};
    assign conf_upd = (conf_sum > {1'b0, abrs_pkg::ONE_Q8}) ? abrs_pkg::ONE_Q8 : conf_sum[8:0];

    assign dec_conf = prod[16:8];
    assign drop     = dec_conf < min_conf_reg;

    assign rb_in_range = rb_reg < N_BKT;
    assign last_idx    = idx_reg == LAST_BKT;

    always_comb
    begin
        point_entry.valid    = 1'b1;
        point_entry.range_q4 = rd.valid ? new_dist : nd;
        point_entry.angle    = ang_reg;
        point_entry.qual     = qual_reg;
        point_entry.conf     = rd.valid ? conf_upd : abrs_pkg::ONE_Q8;

        decay_entry       = rd;
        decay_entry.conf  = dec_conf;
        decay_entry.valid = !drop;
    end

    // shared multiplier operands
    always_comb
    begin
        unique case (state_reg)
            S_DIV:
            begin
                mul_a = abrs_pkg::RECIP_100;
                mul_b = {3'b000, ang_sum};
            end
            S_DIFF:
            begin
                mul_a = {9'b0, alpha_eff};
                mul_b = diff;
            end
            S_DMUL:
            begin
                mul_a = {9'b0, decay_sat};
                mul_b = {11'b0, rd.conf};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // table port control
    always_comb
    begin
        tbl_req     = '0;
        tbl_wr_data = point_entry;
        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = idx_reg;
                tbl_wr_data     = '0;
            end
            S_ADDR:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = bkt_calc;
            end
            S_WRITE:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = bkt_reg;
            end
            S_READ:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = rb_in_range ? rb_reg : '0;
            end
            S_DRD:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = idx_reg;
            end
            S_DWR:
            begin
                tbl_req.wr_en   = rd.valid;
                tbl_req.wr_addr = idx_reg;
                tbl_wr_data     = decay_entry;
            end
            default:
            begin
                tbl_req = '0;
            end
        endcase
    end

    always_comb
    begin
        live_next = live_reg;
        if ((state_reg == S_WRITE) && !rd.valid)
        begin
            live_next = live_reg + 9'd1;
        end
        else if ((state_reg == S_DWR) && rd.valid && drop)
        begin
            live_next = live_reg - 9'd1;
        end
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ang_reg       <= '0;
            dist_reg      <= '0;
            qual_reg      <= '0;
            rb_reg        <= '0;
            bkt_reg       <= '0;
            idx_reg       <= '0;
            live_reg      <= '0;
            done_reg      <= 1'b0;
            present_reg   <= 1'b0;
            index_reg     <= '0;
            dist_out_reg  <= '0;
            angle_out_reg <= '0;
            qual_out_reg  <= '0;
            conf_out_reg  <= '0;
            live_out_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            live_reg <= live_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= last_idx ? '0 : idx_reg + 9'd1;
                    if (last_idx)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        ang_reg  <= angle_centideg;
                        dist_reg <= distance_mm;
                        qual_reg <= quality;
                        rb_reg   <= read_bucket;
                        idx_reg  <= '0;
                        unique case (abrs_pkg::opcode_t'(opcode))
                            abrs_pkg::OP_POINT: state_reg <= S_DIV;
                            abrs_pkg::OP_DECAY: state_reg <= S_DRD;
                            abrs_pkg::OP_READ:  state_reg <= S_READ;
                            abrs_pkg::OP_NOP:   state_reg <= S_NOP;
                        endcase
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    bkt_reg   <= bkt_calc;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    done_reg      <= 1'b1;
                    present_reg   <= 1'b1;
                    index_reg     <= bkt_reg;
                    dist_out_reg  <= point_entry.range_q4;
                    angle_out_reg <= point_entry.angle;
                    qual_out_reg  <= point_entry.qual;
                    conf_out_reg  <= point_entry.conf;
                    live_out_reg  <= live_next;
                    state_reg     <= S_IDLE;
                end
                S_READ:
                begin
                    state_reg <= S_RDOUT;
                end
                S_RDOUT:
                begin
                    done_reg      <= 1'b1;
                    present_reg   <= rb_in_range && rd.valid;
                    index_reg     <= rb_reg;
                    dist_out_reg  <= (rb_in_range && rd.valid) ? rd.range_q4 : '0;
                    angle_out_reg <= (rb_in_range && rd.valid) ? rd.angle : '0;
                    qual_out_reg  <= (rb_in_range && rd.valid) ? rd.qual : '0;
                    conf_out_reg  <= (rb_in_range && rd.valid) ? rd.conf : '0;
                    live_out_reg  <= live_reg;
                    state_reg     <= S_IDLE;
                end
                S_DRD:
                begin
                    state_reg <= S_DMUL;
                end
                S_DMUL:
                begin
                    state_reg <= S_DWR;
                end
                S_DWR:
                begin
                    idx_reg <= last_idx ? '0 : idx_reg + 9'd1;
                    if (last_idx)
                    begin
                        done_reg      <= 1'b1;
                        present_reg   <= 1'b0;
                        index_reg     <= '0;
                        dist_out_reg  <= '0;
                        angle_out_reg <= '0;
                        qual_out_reg  <= '0;
                        conf_out_reg  <= '0;
                        live_out_reg  <= live_next;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DRD;
                    end
                end
                S_NOP:
                begin
                    done_reg      <= 1'b1;
                    present_reg   <= 1'b0;
                    index_reg     <= '0;
                    dist_out_reg  <= '0;
                    angle_out_reg <= '0;
                    qual_out_reg  <= '0;
                    conf_out_reg  <= '0;
                    live_out_reg  <= live_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = state_reg != S_IDLE;
    assign done              = done_reg;
    assign entry_present     = present_reg;
    assign bucket_index      = index_reg;
    assign smoothed_distance = dist_out_reg;
    assign last_angle        = angle_out_reg;
    assign last_quality      = qual_out_reg;
    assign confidence        = conf_out_reg;
    assign live_entries      = live_out_reg;

    `ABRS_ASSERT_CLK(a_live_bound, live_reg <= N_BKT, "live count above bucket count")
    `ABRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `ABRS_ASSERT_CLK(a_done_after_work, done_reg |-> $past(state_reg != S_IDLE), "strobe without work")
    `ABRS_ASSERT_CLK(a_no_write_idle, (state_reg == S_IDLE) |-> !tbl_req.wr_en, "table write while idle")

endmodule

// ===== dv/abrs_table_checker.sv =====
// result checker: tracks the bucket table and compares every reported word
module abrs_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] angle_centideg,
    input  logic [15:0] distance_mm,
    input  logic [7:0]  quality,
    input  logic [8:0]  read_bucket,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        done,
    input  logic        entry_present,
    input  logic [8:0]  bucket_index,
    input  logic [19:0] smoothed_distance,
    input  logic [15:0] last_angle,
    input  logic [7:0]  last_quality,
    input  logic [8:0]  confidence,
    input  logic [8:0]  live_entries,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        present;
        logic [abrs_pkg::BKT_W-1:0]  index;
        logic [abrs_pkg::DIST_W-1:0] range_q4;
        logic [15:0]                 angle;
        logic [7:0]                  qual;
        logic [8:0]                  conf;
        logic [8:0]                  live;
    } bucket_report_t;

    logic [8:0]                  alpha_reg;
    logic [15:0]                 jump_mm_reg;
    logic [8:0]                  decay_reg;
    logic [8:0]                  floor_reg;
    logic [8:0]                  boost_reg;

    logic                        slot_live  [abrs_pkg::NUM_BUCKETS];
    logic [abrs_pkg::DIST_W-1:0] slot_dist  [abrs_pkg::NUM_BUCKETS];
    logic [15:0]                 slot_angle [abrs_pkg::NUM_BUCKETS];
    logic [7:0]                  slot_qual  [abrs_pkg::NUM_BUCKETS];
    logic [8:0]                  slot_conf  [abrs_pkg::NUM_BUCKETS];
    logic [8:0]                  live_total;

    bucket_report_t              expected_reports[$];
    bucket_report_t              head_report;

    function automatic bucket_report_t report_of(input logic [8:0] idx, input int unsigned b);
        bucket_report_t r;
        r = '0;
        r.index = idx;
        if (b < abrs_pkg::NUM_BUCKETS && slot_live[b])
        begin
            r.present  = 1'b1;
            r.range_q4 = slot_dist[b];
            r.angle    = slot_angle[b];
            r.qual     = slot_qual[b];
            r.conf     = slot_conf[b];
        end
        r.live = live_total;
        return r;
    endfunction

    // updates the table for one command word and returns its report
    function automatic bucket_report_t apply_word(input abrs_pkg::opcode_t op,
                                                  input logic [15:0] ang,
                                                  input logic [15:0] dist_in,
                                                  input logic [7:0] qual_in,
                                                  input logic [8:0] rd_idx);
        int unsigned     b;
        int unsigned     nd;
        int unsigned     od;
        int unsigned     diff;
        int unsigned     a;
        int unsigned     d;
        int unsigned     c;
        int unsigned     i;
        longint unsigned mix;
        case (op)
            abrs_pkg::OP_POINT:
            begin
                b  = ((32'(ang) + 32'd50) / 32'd100) % 32'(abrs_pkg::NUM_BUCKETS);
                nd = 32'(dist_in) << 4;
                if (!slot_live[b])
                begin
                    slot_live[b] = 1'b1;
                    slot_dist[b] = nd[abrs_pkg::DIST_W-1:0];
                    slot_conf[b] = abrs_pkg::ONE_Q8;
                    live_total   = live_total + 9'd1;
                end
                else
                begin
                    od   = 32'(slot_dist[b]);
                    diff = (nd > od) ? nd - od : od - nd;
                    a    = (alpha_reg > abrs_pkg::ONE_Q8) ? 32'(abrs_pkg::ONE_Q8)
                                                          : 32'(alpha_reg);
                    // big jump: follow the new distance at half weight
                    if (diff > (32'(jump_mm_reg) << 4))
                        a = a >> 1;
                    mix = (64'(a) * 64'(nd) + 64'(256 - a) * 64'(od) + 64'd128) >> 8;
                    slot_dist[b] = mix[abrs_pkg::DIST_W-1:0];
                    c = 32'(slot_conf[b]) + 32'(boost_reg);
                    slot_conf[b] = (c > 32'(abrs_pkg::ONE_Q8)) ? abrs_pkg::ONE_Q8 : c[8:0];
                end
                slot_angle[b] = ang;
                slot_qual[b]  = qual_in;
                return report_of(b[8:0], b);
            end
            abrs_pkg::OP_DECAY:
            begin
                d = (decay_reg > abrs_pkg::ONE_Q8) ? 32'(abrs_pkg::ONE_Q8) : 32'(decay_reg);
                for (i = 0; i < abrs_pkg::NUM_BUCKETS; i++)
                begin
                    if (slot_live[i])
                    begin
                        c = (32'(slot_conf[i]) * d) >> 8;
                        slot_conf[i] = c[8:0];
                        if (slot_conf[i] < floor_reg)
                        begin
                            slot_live[i] = 1'b0;
                            live_total   = live_total - 9'd1;
                        end
                    end
                end
                return report_of(9'd0, abrs_pkg::NUM_BUCKETS);
            end
            abrs_pkg::OP_READ:
                return report_of(rd_idx, 32'(rd_idx));
            default:
                return report_of(9'd0, abrs_pkg::NUM_BUCKETS);
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   = abrs_pkg::ALPHA_RESET;
            jump_mm_reg = abrs_pkg::THRESHOLD_RESET;
            decay_reg   = abrs_pkg::DECAY_RESET;
            floor_reg   = abrs_pkg::MIN_CONF_RESET;
            boost_reg   = abrs_pkg::BOOST_RESET;
            for (int k = 0; k < abrs_pkg::NUM_BUCKETS; k++)
            begin
                slot_live[k]  = 1'b0;
                slot_dist[k]  = '0;
                slot_angle[k] = '0;
                slot_qual[k]  = '0;
                slot_conf[k]  = '0;
            end
            live_total = '0;
            expected_reports.delete();
            pending_count = 0;
        end
        else
        begin
            // a result retires before a word accepted on the same edge is predicted
            if (done)
            begin
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word with nothing outstanding, bucket %0d",
                             $time, bucket_index);
                end
                else
                begin
                    head_report = expected_reports.pop_front();
                    check_field("entry_present", 32'(head_report.present),
                                32'(entry_present));
                    check_field("bucket_index", 32'(head_report.index), 32'(bucket_index));
                    check_field("smoothed_distance", 32'(head_report.range_q4),
                                32'(smoothed_distance));
                    check_field("last_angle", 32'(head_report.angle), 32'(last_angle));
                    check_field("last_quality", 32'(head_report.qual), 32'(last_quality));
                    check_field("confidence", 32'(head_report.conf), 32'(confidence));
                    check_field("live_entries", 32'(head_report.live), 32'(live_entries));
                    checked_count++;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    abrs_pkg::CFG_ALPHA:     alpha_reg   = cfg_data[8:0];
                    abrs_pkg::CFG_THRESHOLD: jump_mm_reg = cfg_data;
                    abrs_pkg::CFG_DECAY:     decay_reg   = cfg_data[8:0];
                    abrs_pkg::CFG_MIN_CONF:  floor_reg   = cfg_data[8:0];
                    abrs_pkg::CFG_BOOST:     boost_reg   = cfg_data[8:0];
                    default:                 ;
                endcase
            end
            if (start && !busy)
                expected_reports = {expected_reports,
                                    apply_word(abrs_pkg::opcode_t'(opcode), angle_centideg,
                                               distance_mm, quality, read_bucket)};
            pending_count = expected_reports.size();
        end
    end

endmodule

// ===== dv/angle_bucket_range_smoother_tb.sv =====
// testbench top: drives command words and register writes, reports the verdict
module angle_bucket_range_smoother_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_UNUSED  = 3'd7;
    localparam int         PHASES      = 6;
    localparam int         PHASE_WORDS = 325;
    localparam int         HOT_SLOTS   = 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [15:0] angle_centideg;
    logic [15:0] distance_mm;
    logic [7:0]  quality;
    logic [8:0]  read_bucket;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic        entry_present;
    logic [8:0]  bucket_index;
    logic [19:0] smoothed_distance;
    logic [15:0] last_angle;
    logic [7:0]  last_quality;
    logic [8:0]  confidence;
    logic [8:0]  live_entries;

    int          fail_count;
    int          pending_count;
    int          checked_count;

    int          point_words;
    int          read_words;
    int          decay_words;
    int          nop_words;
    int          settings_used;
    int unsigned idle_pct;
    int unsigned hot_bucket [HOT_SLOTS];
    int unsigned hot_dist   [HOT_SLOTS];

    angle_bucket_range_smoother DUT (.*);

    abrs_table_checker u_table_check (.*);

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_word(input abrs_pkg::opcode_t op, input logic [15:0] ang,
                             input logic [15:0] dist_mm, input logic [7:0] qual,
                             input logic [8:0] rb);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start          = 1'b1;
        opcode         = op;
        angle_centideg = ang;
        distance_mm    = dist_mm;
        quality        = qual;
        read_bucket    = rb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (op)
            abrs_pkg::OP_POINT: point_words++;
            abrs_pkg::OP_READ:  read_words++;
            abrs_pkg::OP_DECAY: decay_words++;
            default:            nop_words++;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // q1.8 factor with junk in the unused upper bits of the word
    function automatic logic [15:0] pick_factor();
        logic [8:0] v;
        case ($urandom_range(3))
            0:       v = 9'd0;
            1:       v = abrs_pkg::ONE_Q8;
            2:       v = 9'h1FF;
            default: v = 9'($urandom_range(0, 511));
        endcase
        return {7'($urandom_range(0, 127)), v};
    endfunction

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic new_setting();
        drain();
        write_reg(abrs_pkg::CFG_ALPHA, pick_factor());
        write_reg(abrs_pkg::CFG_THRESHOLD, pick_threshold());
        write_reg(abrs_pkg::CFG_DECAY, pick_factor());
        write_reg(abrs_pkg::CFG_MIN_CONF, pick_factor());
        write_reg(abrs_pkg::CFG_BOOST, pick_factor());
        settings_used++;
        for (int k = 0; k < HOT_SLOTS; k++)
        begin
            hot_bucket[k] = $urandom_range(0, abrs_pkg::NUM_BUCKETS - 1);
            hot_dist[k]   = $urandom_range(0, 65535);
        end
    endtask

    // mostly repeated hits on a few buckets so smoothing and decay get deep
    task automatic rand_word();
        int unsigned pick;
        int unsigned k;
        int unsigned sel;
        int unsigned step;
        logic [15:0] ang;
        logic [15:0] dist_mm;
        logic [8:0]  rb;
        pick = $urandom_range(99);
        k    = $urandom_range(HOT_SLOTS - 1);
        sel  = $urandom_range(9);
        if (pick < 60)
        begin
            if (sel < 7)
                ang = 16'((hot_bucket[k] * 100 + 35950 + $urandom_range(0, 99)) % 36000);
            else if (sel < 9)
                ang = 16'($urandom_range(0, 35999));
            else
                ang = 16'($urandom_range(36000, 65535));
            if ($urandom_range(1))
                dist_mm = 16'($urandom);
            else
            begin
                step = $urandom_range(0, 1200);
                if ($urandom_range(1) && hot_dist[k] + step <= 65535)
                    dist_mm = 16'(hot_dist[k] + step);
                else if (hot_dist[k] >= step)
                    dist_mm = 16'(hot_dist[k] - step);
                else
                    dist_mm = 16'(hot_dist[k] + step);
            end
            send_word(abrs_pkg::OP_POINT, ang, dist_mm, 8'($urandom), 9'($urandom));
        end
        else if (pick < 88)
        begin
            if (sel < 8)
                rb = 9'(hot_bucket[k]);
            else if (sel < 9)
                rb = 9'($urandom_range(0, abrs_pkg::NUM_BUCKETS - 1));
            else
                rb = 9'($urandom_range(abrs_pkg::NUM_BUCKETS, 511));
            send_word(abrs_pkg::OP_READ, 16'($urandom), 16'($urandom), 8'($urandom), rb);
        end
        else if (pick < 94)
            send_word(abrs_pkg::OP_DECAY, 16'($urandom), 16'($urandom), 8'($urandom),
                      9'($urandom));
        else
            send_word(abrs_pkg::OP_NOP, 16'($urandom), 16'($urandom), 8'($urandom),
                      9'($urandom));
    endtask

    initial
    begin
        int phase_no;
        int n;
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = abrs_pkg::OP_POINT;
        angle_centideg = '0;
        distance_mm    = '0;
        quality        = '0;
        read_bucket    = '0;
        cfg_write      = 1'b0;
        cfg_index      = abrs_pkg::CFG_ALPHA;
        cfg_data       = '0;
        idle_pct       = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: rounding edges, wrap, jump exactly at threshold
        send_word(abrs_pkg::OP_READ,  16'd0,     16'd0,     8'd0,   9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd0,     16'd0,     8'd0,   9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd35949, 16'hFFFF,  8'hFF,  9'h1FF);
        send_word(abrs_pkg::OP_POINT, 16'd35950, 16'hFFFF,  8'hAA,  9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd10000, 16'd1000,  8'd1,   9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd10000, 16'd1500,  8'd2,   9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd10049, 16'd1502,  8'd3,   9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd10050, 16'd7,     8'd4,   9'd0);
        send_word(abrs_pkg::OP_POINT, 16'hFFFF,  16'hAAAA,  8'h55,  9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd35999, 16'h5555,  8'h80,  9'd0);
        send_word(abrs_pkg::OP_READ,  16'd0,     16'd0,     8'd0,   9'd359);
        send_word(abrs_pkg::OP_READ,  16'd0,     16'd0,     8'd0,   9'd360);
        send_word(abrs_pkg::OP_READ,  16'hFFFF,  16'hFFFF,  8'hFF,  9'h1FF);
        send_word(abrs_pkg::OP_NOP,   16'hFFFF,  16'hFFFF,  8'hFF,  9'h1FF);
        send_word(abrs_pkg::OP_DECAY, 16'd0,     16'd0,     8'd0,   9'd0);

        // oversized alpha and boost, decay factor of zero, no floor
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(abrs_pkg::CFG_ALPHA, 16'hFFFF);
        write_reg(abrs_pkg::CFG_THRESHOLD, 16'hFFFF);
        write_reg(abrs_pkg::CFG_BOOST, 16'h01FF);
        write_reg(abrs_pkg::CFG_DECAY, 16'h0000);
        write_reg(abrs_pkg::CFG_MIN_CONF, 16'h0000);
        send_word(abrs_pkg::OP_POINT, 16'd10000, 16'hFFFF,  8'd9,   9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd0,     16'd0,     8'd10,  9'd0);
        send_word(abrs_pkg::OP_DECAY, 16'd0,     16'd0,     8'd0,   9'd0);
        send_word(abrs_pkg::OP_READ,  16'd0,     16'd0,     8'd0,   9'd100);

        // frozen distance, oversized decay, floor above one drops everything
        drain();
        write_reg(abrs_pkg::CFG_ALPHA, 16'h0000);
        write_reg(abrs_pkg::CFG_THRESHOLD, 16'h0000);
        write_reg(abrs_pkg::CFG_BOOST, 16'h0000);
        write_reg(abrs_pkg::CFG_DECAY, 16'h01FF);
        write_reg(abrs_pkg::CFG_MIN_CONF, 16'h01FF);
        send_word(abrs_pkg::OP_POINT, 16'd10000, 16'd100,   8'd11,  9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd20000, 16'd9,     8'd12,  9'd0);
        send_word(abrs_pkg::OP_DECAY, 16'd0,     16'd0,     8'd0,   9'd0);
        send_word(abrs_pkg::OP_READ,  16'd0,     16'd0,     8'd0,   9'd200);

        // full alpha halved by any jump, half decay against a floor of one
        drain();
        write_reg(abrs_pkg::CFG_ALPHA, 16'h0100);
        write_reg(abrs_pkg::CFG_DECAY, 16'h0080);
        write_reg(abrs_pkg::CFG_MIN_CONF, 16'h0100);
        write_reg(abrs_pkg::CFG_BOOST, 16'h0100);
        send_word(abrs_pkg::OP_POINT, 16'd5000,  16'd3,     8'd13,  9'd0);
        send_word(abrs_pkg::OP_POINT, 16'd5000,  16'd4,     8'd14,  9'd0);
        send_word(abrs_pkg::OP_DECAY, 16'd0,     16'd0,     8'd0,   9'd0);
        settings_used = 4;

        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            new_setting();
            case (phase_no / 2)
                0:       idle_pct = 10;
                1:       idle_pct = 61;
                default: idle_pct = 0;
            endcase
            for (n = 0; n < PHASE_WORDS; n++)
                rand_word();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("run covered %0d command words: %0d points, %0d reads, %0d decays, %0d nops",
                 point_words + read_words + decay_words + nop_words,
                 point_words, read_words, decay_words, nop_words);
        $display("%0d results compared over %0d register settings, sender idle 10/61/0 percent",
                 checked_count, settings_used);
        if (fail_count + pending_count == 0)
            $display("angle_bucket_range_smoother verification clean");
        else
            $display("angle_bucket_range_smoother verification failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("angle_bucket_range_smoother verification failed");
        $finish;
    end

endmodule
